// File: rtl/ffbp_pkg.sv
`timescale 1ns / 1ps

package ffbp_pkg;

  localparam int MAX_BINS_DEF  = 256;
  localparam int SIZE_BITS_DEF = 16;

  localparam int CFG_W      = 16;
  localparam int SIZE_IN_W  = 16;
  localparam int IDX_OUT_W  = 8;
  localparam int CNT_OUT_W  = 9;

  localparam logic [CFG_W-1:0] CAP_RESET = 16'hFFFF;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

endpackage

// File: rtl/first_fit_bin_packer_core.sv
`timescale 1ns / 1ps
// channel   | ports                                           | handshake
// ----------+-------------------------------------------------+-------------------------
// input     | in_op, in_item_size, in_last_item               | start && !busy
// result    | out_bin_index, out_new_bin, out_bin_count,      | out_valid, one cycle
//           | out_oversize, out_table_full, out_job_done      |
// config    | cfg_bin_capacity                                | cfg_we
//
// a clear transaction leaves busy low and its result follows in the next cycle
// a place transaction keeps busy high while it scans the open bins, and once the scan ends
// its result follows in the next cycle; one fill read per cycle from the single-port
// bin table, compared in the shared add/compare unit
// synchronous active-low reset empties the table; bin fills are not cleared
// the receiver cannot stall; each result is shown for exactly one cycle

module first_fit_bin_packer_core #(
  parameter int MAX_BINS  = ffbp_pkg::MAX_BINS_DEF,
  parameter int SIZE_BITS = ffbp_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_op,
  input  logic [ffbp_pkg::SIZE_IN_W-1:0]  in_item_size,
  input  logic                            in_last_item,
  output logic                            out_valid,
  output logic [ffbp_pkg::IDX_OUT_W-1:0]  out_bin_index,
  output logic                            out_new_bin,
  output logic [ffbp_pkg::CNT_OUT_W-1:0]  out_bin_count,
  output logic                            out_oversize,
  output logic                            out_table_full,
  output logic                            out_job_done,
  input  logic                            cfg_we,
  input  logic [ffbp_pkg::CFG_W-1:0]      cfg_bin_capacity
);

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int CNT_W = $clog2(MAX_BINS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state_r, state_nxt;
  logic [ffbp_pkg::CFG_W-1:0] cap_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     ptr_r, ptr_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 last_r, last_nxt;

  logic [SIZE_BITS-1:0] mem [MAX_BINS];
  logic [SIZE_BITS-1:0] rd_data_r;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;

  logic [SIZE_BITS+ffbp_pkg::SIZE_IN_W-1:0] size_ext;
  logic [SIZE_BITS+ffbp_pkg::CFG_W-1:0]     cap_ext;
  logic [SIZE_BITS-1:0] cap_eff;

  logic [SIZE_BITS-1:0] fu_fill;
  logic [SIZE_BITS-1:0] fu_sum;
  logic                 fu_fits;

  logic                 accept;
  logic                 res_valid;
  logic [CNT_W-1:0]     res_idx;
  logic                 res_new, res_over, res_full;
  logic [31:0]          idx_wide, cnt_wide;

  logic                 out_valid_r;
  logic [ffbp_pkg::IDX_OUT_W-1:0] out_bin_index_r;
  logic                 out_new_bin_r;
  logic [ffbp_pkg::CNT_OUT_W-1:0] out_bin_count_r;
  logic                 out_oversize_r;
  logic                 out_table_full_r;
  logic                 out_job_done_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign size_ext = {{SIZE_BITS{1'b0}}, in_item_size};
  assign cap_ext  = {{SIZE_BITS{1'b0}}, cap_r};
  assign cap_eff  = cap_ext[SIZE_BITS-1:0];

  assign fu_fill = pend_r ? rd_data_r : '0;

  ffbp_fit_unit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_fit (
    .fill (fu_fill),
    .size (size_r),
    .cap  (cap_eff),
    .sum  (fu_sum),
    .fits (fu_fits)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    cmp_idx_nxt = cmp_idx_r;
    pend_nxt    = pend_r;
    size_nxt    = size_r;
    last_nxt    = last_r;
    rd_en       = 1'b0;
    rd_addr     = ptr_r[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = cmp_idx_r;
    res_valid   = 1'b0;
    res_idx     = '0;
    res_new     = 1'b0;
    res_over    = 1'b0;
    res_full    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_last_item;
          if (in_op == ffbp_pkg::OP_CLEAR) begin
            count_nxt = '0;
            res_valid = 1'b1;
          end else begin
            size_nxt  = size_ext[SIZE_BITS-1:0];
            ptr_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && fu_fits) begin
          // first open bin that fits
          wr_en     = 1'b1;
          wr_addr   = cmp_idx_r;
          res_valid = 1'b1;
          res_idx   = CNT_W'(cmp_idx_r);
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else if (ptr_r < count_r) begin
          rd_en       = 1'b1;
          rd_addr     = ptr_r[IDX_W-1:0];
          cmp_idx_nxt = ptr_r[IDX_W-1:0];
          pend_nxt    = 1'b1;
          ptr_nxt     = ptr_r + 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          // no open bin fits; unit now compares size against capacity
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          if (count_r < CNT_W'(MAX_BINS)) begin
            wr_en     = 1'b1;
            wr_addr   = count_r[IDX_W-1:0];
            res_idx   = count_r;
            res_new   = 1'b1;
            res_over  = !fu_fits;
            count_nxt = count_r + 1'b1;
          end else begin
            res_full = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= fu_sum;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cap_r   <= ffbp_pkg::CAP_RESET;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      if (cfg_we) begin
        cap_r <= cfg_bin_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    size_r    <= size_nxt;
    last_r    <= last_nxt;
  end

  assign idx_wide = 32'(res_idx);
  assign cnt_wide = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_bin_index_r  <= idx_wide[ffbp_pkg::IDX_OUT_W-1:0];
      out_new_bin_r    <= res_new;
      out_bin_count_r  <= cnt_wide[ffbp_pkg::CNT_OUT_W-1:0];
      out_oversize_r   <= res_over;
      out_table_full_r <= res_full;
      out_job_done_r   <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_index  = out_bin_index_r;
  assign out_new_bin    = out_new_bin_r;
  assign out_bin_count  = out_bin_count_r;
  assign out_oversize   = out_oversize_r;
  assign out_table_full = out_table_full_r;
  assign out_job_done   = out_job_done_r;

endmodule

// File: rtl/ffbp_fit_unit.sv
`timescale 1ns / 1ps

module ffbp_fit_unit #(
  parameter int SIZE_BITS = ffbp_pkg::SIZE_BITS_DEF
) (
  input  logic [SIZE_BITS-1:0] fill,
  input  logic [SIZE_BITS-1:0] size,
  input  logic [SIZE_BITS-1:0] cap,
  output logic [SIZE_BITS-1:0] sum,
  output logic                 fits
);

  logic [SIZE_BITS:0] full_sum;

  assign full_sum = {1'b0, fill} + {1'b0, size};
  assign sum      = full_sum[SIZE_BITS-1:0];
  assign fits     = (full_sum <= {1'b0, cap});

endmodule

// File: rtl/ffbp_checker.sv
`timescale 1ns / 1ps

module ffbp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           in_op,
  input logic                           out_valid,
  input logic [ffbp_pkg::IDX_OUT_W-1:0] out_bin_index,
  input logic                           out_new_bin,
  input logic [ffbp_pkg::CNT_OUT_W-1:0] out_bin_count,
  input logic                           out_oversize,
  input logic                           out_table_full
);

  // a result only follows an accepted transaction or a running search
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

  // a dropped item carries no placement
  a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |->
      (out_bin_index == '0 && !out_new_bin && !out_oversize))
    else $error("dropped item reports a placement");

  // an oversize item always gets a fresh bin
  a_oversize_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_oversize) |-> out_new_bin)
    else $error("oversize item without new bin");

  // a clear empties the table and its result follows in the next cycle
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy && in_op == ffbp_pkg::OP_CLEAR) |=>
      (out_valid && out_bin_count == '0 && !out_new_bin && !out_table_full && !busy))
    else $error("clear did not empty the table");

  // a place transaction starts a search
  a_place_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy && in_op == ffbp_pkg::OP_PLACE) |=> busy)
    else $error("place transaction did not start a search");

endmodule

bind first_fit_bin_packer_core ffbp_checker u_ffbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_op          (in_op),
  .out_valid      (out_valid),
  .out_bin_index  (out_bin_index),
  .out_new_bin    (out_new_bin),
  .out_bin_count  (out_bin_count),
  .out_oversize   (out_oversize),
  .out_table_full (out_table_full)
);

// File: tb/first_fit_bin_packer_core_tb.sv
`timescale 1ns / 1ps

module first_fit_bin_packer_core_tb;

  typedef struct {
    bit                             is_cfg;
    logic [ffbp_pkg::CFG_W-1:0]     cap;
    logic                           op;
    logic [ffbp_pkg::SIZE_IN_W-1:0] size;
    logic                           last;
  } request_t;

  typedef struct packed {
    logic [ffbp_pkg::IDX_OUT_W-1:0] bin_index;
    logic                           new_bin;
    logic [ffbp_pkg::CNT_OUT_W-1:0] bin_count;
    logic                           oversize;
    logic                           table_full;
    logic                           job_done;
  } placement_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           in_op = ffbp_pkg::OP_PLACE;
  logic [ffbp_pkg::SIZE_IN_W-1:0] in_item_size = '0;
  logic                           in_last_item = 1'b0;
  logic                           out_valid;
  logic [ffbp_pkg::IDX_OUT_W-1:0] out_bin_index;
  logic                           out_new_bin;
  logic [ffbp_pkg::CNT_OUT_W-1:0] out_bin_count;
  logic                           out_oversize;
  logic                           out_table_full;
  logic                           out_job_done;
  logic                           cfg_we = 1'b0;
  logic [ffbp_pkg::CFG_W-1:0]     cfg_bin_capacity = ffbp_pkg::CAP_RESET;

  request_t   pending_requests[$];
  placement_t expected_placements[$];
  request_t   cur_req;

  // packer model
  logic [ffbp_pkg::SIZE_BITS_DEF-1:0] fill_model[ffbp_pkg::MAX_BINS_DEF];
  int unsigned                        open_model = 0;
  logic [ffbp_pkg::CFG_W-1:0]         cap_model = ffbp_pkg::CAP_RESET;

  int gap_left = 0;
  int settle = 0;
  bit idle_on = 1'b1;
  int mismatches = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int n_reuse = 0;
  int n_new = 0;
  int n_over = 0;
  int n_drop = 0;
  int n_clear = 0;

  first_fit_bin_packer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_item_size     (in_item_size),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_bin_index    (out_bin_index),
    .out_new_bin      (out_new_bin),
    .out_bin_count    (out_bin_count),
    .out_oversize     (out_oversize),
    .out_table_full   (out_table_full),
    .out_job_done     (out_job_done),
    .cfg_we           (cfg_we),
    .cfg_bin_capacity (cfg_bin_capacity)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic placement_t first_fit_place(input request_t req);
    placement_t r;
    int j;
    bit hit;
    logic [ffbp_pkg::SIZE_BITS_DEF:0] sum;
    r = '0;
    r.job_done = req.last;
    hit = 1'b0;
    if (req.op == ffbp_pkg::OP_CLEAR) begin
      open_model = 0;
      n_clear++;
    end else begin
      for (j = 0; j < open_model && !hit; j++) begin
        sum = {1'b0, fill_model[j]} + {1'b0, req.size};
        if (sum <= {1'b0, cap_model}) begin
          fill_model[j] = sum[ffbp_pkg::SIZE_BITS_DEF-1:0];
          r.bin_index = j[ffbp_pkg::IDX_OUT_W-1:0];
          hit = 1'b1;
          n_reuse++;
        end
      end
      if (!hit) begin
        if (open_model < ffbp_pkg::MAX_BINS_DEF) begin
          fill_model[open_model] = req.size;
          r.bin_index = open_model[ffbp_pkg::IDX_OUT_W-1:0];
          r.new_bin = 1'b1;
          r.oversize = (req.size > cap_model);
          open_model++;
          n_new++;
          if (r.oversize) n_over++;
        end else begin
          r.table_full = 1'b1;
          n_drop++;
        end
      end
    end
    r.bin_count = open_model[ffbp_pkg::CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic add_place(input logic [ffbp_pkg::SIZE_IN_W-1:0] size, input logic last);
    request_t r;
    r = '{is_cfg: 1'b0, cap: '0, op: ffbp_pkg::OP_PLACE, size: size, last: last};
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic add_clear(input logic [ffbp_pkg::SIZE_IN_W-1:0] size, input logic last);
    request_t r;
    r = '{is_cfg: 1'b0, cap: '0, op: ffbp_pkg::OP_CLEAR, size: size, last: last};
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic add_cap(input logic [ffbp_pkg::CFG_W-1:0] cap);
    request_t r;
    r = '{is_cfg: 1'b1, cap: cap, op: ffbp_pkg::OP_PLACE, size: '0, last: 1'b0};
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic check_field(input string fname, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin : driver
    bit drive;
    bit we_nxt;
    request_t head;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      gap_left = 0;
      settle = 0;
    end else begin
      drive = start;
      we_nxt = 1'b0;
      if (start && !busy) begin
        expected_placements.insert(expected_placements.size(), first_fit_place(cur_req));
        n_items++;
        drive = 1'b0;
        if ($urandom_range(0, 31) == 0) idle_on = !idle_on;
        gap_left = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (!drive && pending_requests.size() > 0) begin
        if (pending_requests[0].is_cfg) begin
          // capacity changes only once the block has gone quiet
          if (expected_placements.size() == 0 && !busy) settle++;
          else settle = 0;
          if (settle >= 8) begin
            head = pending_requests.pop_front();
            cap_model = head.cap;
            cfg_bin_capacity <= head.cap;
            we_nxt = 1'b1;
            settle = 0;
            n_cfg++;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          cur_req = pending_requests.pop_front();
          in_op <= cur_req.op;
          in_item_size <= cur_req.size;
          in_last_item <= cur_req.last;
          drive = 1'b1;
        end
      end
      start <= drive;
      cfg_we <= we_nxt;
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    placement_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (expected_placements.size() == 0) begin
        $error("result transaction with no pending placement");
        mismatches++;
      end else begin
        e = expected_placements.pop_front();
        check_field("bin_index", 16'(e.bin_index), 16'(out_bin_index));
        check_field("new_bin", 16'(e.new_bin), 16'(out_new_bin));
        check_field("bin_count", 16'(e.bin_count), 16'(out_bin_count));
        check_field("oversize", 16'(e.oversize), 16'(out_oversize));
        check_field("table_full", 16'(e.table_full), 16'(out_table_full));
        check_field("job_done", 16'(e.job_done), 16'(out_job_done));
      end
    end
  end

  initial begin
    int p;
    int k;
    int c;
    logic [ffbp_pkg::SIZE_IN_W-1:0] sz;

    // directed
    add_place(16'd0, 1'b0);
    add_place(16'hFFFF, 1'b0);
    add_place(16'd0, 1'b0);
    add_place(16'd1, 1'b0);
    add_place(16'hFFFF, 1'b0);
    add_place(16'h5555, 1'b0);
    add_place(16'hAAAA, 1'b1);
    add_clear(16'hFFFF, 1'b1);
    add_cap(16'd1);
    add_place(16'd2, 1'b0);
    add_place(16'd0, 1'b0);
    add_place(16'd1, 1'b0);
    add_place(16'd0, 1'b0);
    add_place(16'hFFFF, 1'b1);
    add_cap(16'd40000);
    add_place(16'd30000, 1'b0);
    add_place(16'd10000, 1'b0);
    add_place(16'd10001, 1'b0);
    add_cap(16'd100);
    add_place(16'd50, 1'b0);
    add_place(16'd0, 1'b0);
    add_place(16'd100, 1'b1);
    add_clear(16'd0, 1'b0);

    // random jobs over several capacities
    for (p = 0; p < 6; p++) begin
      case (p)
        0: c = 65535;
        1: c = 1;
        2: c = $urandom_range(2, 64);
        default: c = $urandom_range(1, 65535);
      endcase
      add_cap(c[ffbp_pkg::CFG_W-1:0]);
      if ($urandom_range(0, 1)) add_clear(16'($urandom), 1'b0);
      for (k = 0; k < 48; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          add_clear(16'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          if ($urandom_range(0, 7) == 0) sz = 16'($urandom);
          else sz = 16'($urandom_range(0, c));
          add_place(sz, $urandom_range(0, 7) == 0);
        end
      end

      // fill the whole table with items that never share, then overflow it
      if (p == 3) begin
        c = $urandom_range(1, 65535);
        add_cap(c[ffbp_pkg::CFG_W-1:0]);
        add_clear(16'd0, 1'b0);
        for (k = 0; k < ffbp_pkg::MAX_BINS_DEF + 8; k++) begin
          if (k >= ffbp_pkg::MAX_BINS_DEF && $urandom_range(0, 3) == 0) sz = 16'd0;
          else sz = 16'($urandom_range(c / 2 + 1, 65535));
          add_place(sz, $urandom_range(0, 15) == 0);
        end
        add_clear(16'($urandom), 1'b1);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() > 0 || start || expected_placements.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);

    $display("ran %0d transactions (%0d results) over %0d capacity settings",
             n_items, n_results, n_cfg);
    $display("reused %0d bins, opened %0d (%0d oversize), dropped %0d, cleared %0d times",
             n_reuse, n_new, n_over, n_drop, n_clear);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d placements still pending", expected_placements.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
